@@ sv/tun_pkg.sv @@
// shared widths, constants and stage payload types of the triangle unit normal pipeline
// no dependencies
package tun_pkg;

    // coordinate and normal formats
    localparam int CW  = 24;            // coordinate width
    localparam int CFB = 12;            // coordinate fraction bits, direction does not depend on it
    localparam int NF  = 14;            // normal fraction bits
    localparam int OW  = NF + 2;        // normal width, Q2.NF

    // derived datapath widths
    localparam int EW   = CW + 1;       // edge width, signed
    localparam int PW   = 2 * EW;       // product width, signed
    localparam int MW   = 2 * CW + 1;   // cross magnitude width
    localparam int XW   = MW + 1;       // cross width, signed
    localparam int BLW  = $clog2(MW + 1);
    localparam int SW   = 31;           // scaled magnitude width
    localparam int XMW  = (MW > SW) ? MW : SW;
    localparam int SQW  = 2 * SW + 2;   // sum of squares width
    localparam int SQS  = SQW / 2;      // square root steps
    localparam int LW   = SQS;          // length width
    localparam int QW   = NF + 1;       // quotient width
    localparam int DW   = LW + QW;      // divider remainder width
    localparam int ONE  = 2 ** NF;

    typedef logic [8:0][CW-1:0] t_tri;

    typedef struct packed {
        logic [2:0][MW-1:0] mag;
        logic [2:0]         neg;
    } t_cross;

    typedef struct packed {
        logic [2:0][SW-1:0] m;
        logic [2:0]         neg;
        logic               deg;
    } t_side;

    typedef struct packed {
        logic [2:0][OW-1:0] n;
        logic               deg;
    } t_norm;

endpackage

@@ sv/tun_cross.sv @@
// edges and exact cross product, three pipeline stages
// depends on tun_pkg
module tun_cross (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  tun_pkg::t_tri   i_tri,
    output logic            o_valid,
    output tun_pkg::t_cross o_cross
);
    import tun_pkg::*;

    logic signed [EW-1:0] r_e [6];
    logic signed [EW-1:0] n_e [6];
    logic signed [PW-1:0] r_p [6];
    logic [2:0]           r_v;
    t_cross               r_c;
    t_cross               n_c;
    logic signed [XW-1:0] w_c [3];

    // edges from the first vertex
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_e[i]   = EW'($signed(i_tri[3+i])) - EW'($signed(i_tri[i]));
            n_e[3+i] = EW'($signed(i_tri[6+i])) - EW'($signed(i_tri[i]));
        end
    end

    // cross terms, then sign and magnitude
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_c[i] = XW'(r_p[2*i]) - XW'(r_p[2*i+1]);
            n_c.neg[i] = w_c[i][XW-1];
            n_c.mag[i] = w_c[i][XW-1] ? MW'(-w_c[i]) : MW'(w_c[i]);
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    // data stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e    <= n_e;
            r_p[0] <= r_e[1] * r_e[5];
            r_p[1] <= r_e[2] * r_e[4];
            r_p[2] <= r_e[2] * r_e[3];
            r_p[3] <= r_e[0] * r_e[5];
            r_p[4] <= r_e[0] * r_e[4];
            r_p[5] <= r_e[1] * r_e[3];
            r_c    <= n_c;
        end
    end

    assign o_valid = r_v[2];
    assign o_cross = r_c;

endmodule

@@ sv/tun_scale.sv @@
// bit length search, prescale shift, squares and sum of squares, four stages
// depends on tun_pkg
module tun_scale (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  tun_pkg::t_cross i_cross,
    output logic            o_valid,
    output tun_pkg::t_side  o_side,
    output logic [tun_pkg::SQW-1:0] o_sum
);
    import tun_pkg::*;

    logic [3:0]           r_v;
    t_cross               r_c;
    logic [BLW-1:0]       r_bl;
    logic [BLW-1:0]       n_bl;
    logic [MW-1:0]        w_or;
    t_side                r_s1;
    t_side                r_s2;
    t_side                r_s3;
    t_side                n_s1;
    logic [2*SW-1:0]      r_sq [3];
    logic [SQW-1:0]       r_sum;
    logic [XMW-1:0]       w_ext;

    // largest bit length over the three magnitudes
    always_comb begin
        w_or = i_cross.mag[0] | i_cross.mag[1] | i_cross.mag[2];
        n_bl = '0;
        for (int i = 0; i < MW; i++) begin
            if (w_or[i]) n_bl = BLW'(i + 1);
        end
    end

    // shift so the largest magnitude fills the scaled width
    always_comb begin
        n_s1.neg = r_c.neg;
        n_s1.deg = (r_bl == '0);
        w_ext    = '0;
        for (int i = 0; i < 3; i++) begin
            w_ext = XMW'(r_c.mag[i]);
            if (r_bl > BLW'(SW)) begin
                n_s1.m[i] = SW'(w_ext >> (r_bl - BLW'(SW)));
            end else begin
                n_s1.m[i] = SW'(w_ext << (BLW'(SW) - r_bl));
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    // data stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c   <= i_cross;
            r_bl  <= n_bl;
            r_s1  <= n_s1;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= (2*SW)'(r_s1.m[i]) * (2*SW)'(r_s1.m[i]);
            end
            r_s2  <= r_s1;
            r_sum <= SQW'(r_sq[0]) + SQW'(r_sq[1]) + SQW'(r_sq[2]);
            r_s3  <= r_s2;
        end
    end

    assign o_valid = r_v[3];
    assign o_side  = r_s3;
    assign o_sum   = r_sum;

endmodule

@@ sv/tun_sqrt.sv @@
// integer square root, one result bit per pipeline stage
// depends on tun_pkg
module tun_sqrt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  tun_pkg::t_side          i_side,
    input  logic [tun_pkg::SQW-1:0] i_sum,
    output logic                    o_valid,
    output tun_pkg::t_side          o_side,
    output logic [tun_pkg::LW-1:0]  o_len
);
    import tun_pkg::*;

    logic [SQW-1:0] s_x    [SQS];
    logic [SQW-1:0] s_r    [SQS];
    t_side          s_side [SQS];
    logic           s_v    [SQS];
    logic [SQW-1:0] r_x    [SQS];
    logic [SQW-1:0] r_r    [SQS];
    t_side          r_side [SQS];
    logic           r_v    [SQS];

    for (genvar k = 0; k < SQS; k++) begin : g_step
        localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 2 - 2 * k);
        logic [SQW-1:0] w_t;

        // stage source
        if (k == 0) begin : g_first
            assign s_x[k]    = i_sum;
            assign s_r[k]    = '0;
            assign s_side[k] = i_side;
            assign s_v[k]    = i_valid;
        end else begin : g_next
            assign s_x[k]    = r_x[k-1];
            assign s_r[k]    = r_r[k-1];
            assign s_side[k] = r_side[k-1];
            assign s_v[k]    = r_v[k-1];
        end

        assign w_t = s_r[k] + BIT;

        // one trial subtract
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (s_x[k] >= w_t) begin
                    r_x[k] <= s_x[k] - w_t;
                    r_r[k] <= (s_r[k] >> 1) + BIT;
                end else begin
                    r_x[k] <= s_x[k];
                    r_r[k] <= s_r[k] >> 1;
                end
                r_side[k] <= s_side[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= s_v[k];
            end
        end
    end

    assign o_valid = r_v[SQS-1];
    assign o_side  = r_side[SQS-1];
    assign o_len   = LW'(r_r[SQS-1]);

endmodule

@@ sv/tun_div.sv @@
// three lane restoring divider, one quotient bit per stage, then clamp and sign
// depends on tun_pkg
module tun_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  tun_pkg::t_side         i_side,
    input  logic [tun_pkg::LW-1:0] i_len,
    output logic                   o_valid,
    output tun_pkg::t_norm         o_norm
);
    import tun_pkg::*;

    typedef struct packed {
        logic [2:0][DW-1:0] rem;
        logic [2:0][QW-1:0] q;
        logic [LW-1:0]      len;
        logic [2:0]         neg;
        logic               deg;
    } t_dst;

    t_dst  s_d [QW+1];
    logic  s_v [QW+1];
    t_dst  r_d [QW+1];
    logic  r_v [QW+1];
    t_dst  n_pre;
    t_norm n_out;
    t_norm r_out;
    logic  r_ov;
    logic [QW-1:0] w_q;

    // numerator with half the divisor for rounding
    always_comb begin
        n_pre     = '0;
        n_pre.len = i_len;
        n_pre.neg = i_side.neg;
        n_pre.deg = i_side.deg;
        for (int i = 0; i < 3; i++) begin
            n_pre.rem[i] = (DW'(i_side.m[i]) << NF) + DW'(i_len >> 1);
        end
    end

    assign s_d[0] = n_pre;
    assign s_v[0] = i_valid;

    for (genvar k = 1; k <= QW; k++) begin : g_bit
        localparam int SH = QW - k;
        logic [DW-1:0] w_dv;
        t_dst          n_d;

        assign s_d[k] = r_d[k-1];
        assign s_v[k] = r_v[k-1];
        assign w_dv   = DW'(s_d[k].len) << SH;

        // trial subtract per lane
        always_comb begin
            n_d = s_d[k];
            for (int i = 0; i < 3; i++) begin
                if (s_d[k].rem[i] >= w_dv) begin
                    n_d.rem[i]   = s_d[k].rem[i] - w_dv;
                    n_d.q[i][SH] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[k] <= n_d;
            end
        end
    end

    // prep stage register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0] <= s_d[0];
        end
    end

    // valid bits
    for (genvar k = 0; k <= QW; k++) begin : g_v
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= s_v[k];
            end
        end
    end

    // clamp to one, apply sign, zero on degenerate
    always_comb begin
        n_out.deg = r_d[QW].deg;
        w_q       = '0;
        for (int i = 0; i < 3; i++) begin
            w_q = (r_d[QW].q[i] > QW'(ONE)) ? QW'(ONE) : r_d[QW].q[i];
            if (r_d[QW].deg) begin
                n_out.n[i] = '0;
            end else if (r_d[QW].neg[i]) begin
                n_out.n[i] = -OW'(w_q);
            end else begin
                n_out.n[i] = OW'(w_q);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_v[QW];
        end
    end

    assign o_valid = r_ov;
    assign o_norm  = r_out;

endmodule

@@ sv/triangle_unit_normal.sv @@
// top level: unit face normal of a triangle, fully pipelined
// depends on tun_pkg, tun_cross, tun_scale, tun_sqrt, tun_div
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------------------------
//   in      | input     | i_in_valid / o_in_ready    | i_p1_x .. i_p3_z, 24 bit Q12.12
//   out     | output    | o_out_valid / i_out_ready  | o_normal_x/y/z Q2.14, o_degenerate
//
// one word per cycle in and out while the output is not stalled; the square root
// has 32 steps and the divider 15 steps.
// synchronous active low reset clears all valid bits; data registers are not reset.
// the whole pipeline holds while a result waits at the output, so nothing is lost
// or repeated; o_in_ready is high whenever the output register is empty or taken.
module triangle_unit_normal (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [tun_pkg::CW-1:0] i_p1_x,
    input  logic signed [tun_pkg::CW-1:0] i_p1_y,
    input  logic signed [tun_pkg::CW-1:0] i_p1_z,
    input  logic signed [tun_pkg::CW-1:0] i_p2_x,
    input  logic signed [tun_pkg::CW-1:0] i_p2_y,
    input  logic signed [tun_pkg::CW-1:0] i_p2_z,
    input  logic signed [tun_pkg::CW-1:0] i_p3_x,
    input  logic signed [tun_pkg::CW-1:0] i_p3_y,
    input  logic signed [tun_pkg::CW-1:0] i_p3_z,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [tun_pkg::OW-1:0] o_normal_x,
    output logic signed [tun_pkg::OW-1:0] o_normal_y,
    output logic signed [tun_pkg::OW-1:0] o_normal_z,
    output logic                         o_degenerate
);
    import tun_pkg::*;

    logic           w_en;
    t_tri           w_tri;
    logic           w_cv;
    t_cross         w_cross;
    logic           w_sv;
    t_side          w_side;
    logic [SQW-1:0] w_sum;
    logic           w_qv;
    t_side          w_qside;
    logic [LW-1:0]  w_len;
    t_norm          w_norm;

    // global advance
    assign w_en       = i_out_ready | ~o_out_valid;
    assign o_in_ready = w_en;

    assign w_tri = {i_p3_z, i_p3_y, i_p3_x, i_p2_z, i_p2_y, i_p2_x, i_p1_z, i_p1_y, i_p1_x};

    tun_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_tri   (w_tri),
        .o_valid (w_cv),
        .o_cross (w_cross)
    );

    tun_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cv),
        .i_cross (w_cross),
        .o_valid (w_sv),
        .o_side  (w_side),
        .o_sum   (w_sum)
    );

    tun_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sv),
        .i_side  (w_side),
        .i_sum   (w_sum),
        .o_valid (w_qv),
        .o_side  (w_qside),
        .o_len   (w_len)
    );

    tun_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_qv),
        .i_side  (w_qside),
        .i_len   (w_len),
        .o_valid (o_out_valid),
        .o_norm  (w_norm)
    );

    assign o_normal_x   = w_norm.n[0];
    assign o_normal_y   = w_norm.n[1];
    assign o_normal_z   = w_norm.n[2];
    assign o_degenerate = w_norm.deg;

endmodule

@@ sv/tun_chk.sv @@
// port level checks of triangle_unit_normal, attached by bind
// depends on tun_pkg
module tun_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic signed [tun_pkg::CW-1:0] i_p1_x,
    input logic signed [tun_pkg::CW-1:0] i_p1_y,
    input logic signed [tun_pkg::CW-1:0] i_p1_z,
    input logic signed [tun_pkg::CW-1:0] i_p2_x,
    input logic signed [tun_pkg::CW-1:0] i_p2_y,
    input logic signed [tun_pkg::CW-1:0] i_p2_z,
    input logic signed [tun_pkg::CW-1:0] i_p3_x,
    input logic signed [tun_pkg::CW-1:0] i_p3_y,
    input logic signed [tun_pkg::CW-1:0] i_p3_z,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic signed [tun_pkg::OW-1:0] o_normal_x,
    input logic signed [tun_pkg::OW-1:0] o_normal_y,
    input logic signed [tun_pkg::OW-1:0] o_normal_z,
    input logic                          o_degenerate
);
    import tun_pkg::*;

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_normal_x)
            && $stable(o_normal_y) && $stable(o_normal_z) && $stable(o_degenerate))
        else $error("stalled output word changed");

    // degenerate word is the zero vector
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_degenerate |-> o_normal_x == '0 && o_normal_y == '0
            && o_normal_z == '0)
        else $error("degenerate word with nonzero normal");

    // components stay within plus or minus one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $signed(o_normal_x) <= ONE && $signed(o_normal_x) >= -ONE
            && $signed(o_normal_y) <= ONE && $signed(o_normal_y) >= -ONE
            && $signed(o_normal_z) <= ONE && $signed(o_normal_z) >= -ONE)
        else $error("normal component out of range");

    // input side opens whenever the output register frees up
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (i_out_ready || !o_out_valid))
        else $error("input ready does not follow output slot");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind triangle_unit_normal tun_chk u_tun_chk (.*);
